// ===== design/banked_memory_map_macros.svh =====
// ---------------------------------------------------------------------------
// Banked memory map assertion macros
// Shorthand for the concurrent checks of the banked memory map.
// ---------------------------------------------------------------------------
`ifndef BANKED_MEMORY_MAP_MACROS_SVH
`define BANKED_MEMORY_MAP_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define BMM_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("banked memory map check failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define BMM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("banked memory map check failed");

`endif

// ===== design/bmm_pkg.sv =====
// ---------------------------------------------------------------------------
// Banked memory map package
// Codes, decode types and default window parameters shared by the design.
// ---------------------------------------------------------------------------
package bmm_pkg;

   localparam int RAM_AW = 16;
   localparam int DATA_W = 8;

   localparam int BASIC_BASE_DEF  = 40960;
   localparam int BASIC_SIZE_DEF  = 8192;
   localparam int KERNEL_BASE_DEF = 57344;
   localparam int KERNEL_SIZE_DEF = 8192;
   localparam int CHAR_BASE_DEF   = 53248;
   localparam int CHAR_SIZE_DEF   = 4096;

   localparam logic [DATA_W-1:0] DIR_RESET  = 8'h2F;
   localparam logic [DATA_W-1:0] BANK_RESET = 8'h37;

   localparam logic [1:0] SRC_RAM    = 2'd0;
   localparam logic [1:0] SRC_BASIC  = 2'd1;
   localparam logic [1:0] SRC_KERNEL = 2'd2;
   localparam logic [1:0] SRC_CHAR   = 2'd3;

   typedef enum logic [2:0] {
      FUNC_MAPPED_READ = 3'd0,
      FUNC_WRITE       = 3'd1,
      FUNC_RAW_READ    = 3'd2,
      FUNC_RAW_WRITE   = 3'd3,
      FUNC_LOAD_BASIC  = 3'd4,
      FUNC_LOAD_KERNEL = 3'd5,
      FUNC_LOAD_CHAR   = 3'd6
   } func_type;

   typedef enum logic [2:0] {
      SEL_ZERO,
      SEL_PORT,
      SEL_RAM,
      SEL_BASIC,
      SEL_KERNEL,
      SEL_CHAR
   } sel_type;

   typedef enum logic {
      ST_CLEAR,
      ST_RUN
   } state_type;

   typedef struct packed {
      sel_type    sel;
      logic [1:0] source;
      logic       ram_we;
      logic       dir_we;
      logic       bank_we;
      logic       basic_we;
      logic       kernel_we;
      logic       char_we;
   } dec_type;

endpackage

// ===== design/bmm_decode.sv =====
// ---------------------------------------------------------------------------
// Banked memory map request decoder
// Turns one request beat and the bank bits into memory strobes, a read
// source selection and the ROM offsets.
// ---------------------------------------------------------------------------
module bmm_decode #(
   parameter int BASIC_BASE  = bmm_pkg::BASIC_BASE_DEF,
   parameter int BASIC_SIZE  = bmm_pkg::BASIC_SIZE_DEF,
   parameter int KERNEL_BASE = bmm_pkg::KERNEL_BASE_DEF,
   parameter int KERNEL_SIZE = bmm_pkg::KERNEL_SIZE_DEF,
   parameter int CHAR_BASE   = bmm_pkg::CHAR_BASE_DEF,
   parameter int CHAR_SIZE   = bmm_pkg::CHAR_SIZE_DEF,
   parameter int BASIC_AW    = 13,
   parameter int KERNEL_AW   = 13,
   parameter int CHAR_AW     = 12
) (
   input  logic [2:0]                  func,
   input  logic [bmm_pkg::RAM_AW-1:0]  address,
   input  logic [2:0]                  bank_bits,
   output bmm_pkg::dec_type            dec,
   output logic [BASIC_AW-1:0]         basic_addr,
   output logic [KERNEL_AW-1:0]        kernel_addr,
   output logic [CHAR_AW-1:0]          char_addr
);
   import bmm_pkg::*;

   localparam int WIN_W = RAM_AW + 1;

   logic [WIN_W-1:0]  addr_wide;
   logic              in_basic;
   logic              in_kernel;
   logic              in_char;
   logic              is_port;
   logic              load;
   logic [RAM_AW-1:0] basic_off;
   logic [RAM_AW-1:0] kernel_off;
   logic [RAM_AW-1:0] char_off;
   sel_type           ram_sel;

   assign addr_wide = {1'b0, address};
   assign in_basic  = (addr_wide >= WIN_W'(BASIC_BASE))
                   && (addr_wide < WIN_W'(BASIC_BASE) + WIN_W'(BASIC_SIZE));
   assign in_kernel = (addr_wide >= WIN_W'(KERNEL_BASE))
                   && (addr_wide < WIN_W'(KERNEL_BASE) + WIN_W'(KERNEL_SIZE));
   assign in_char   = (addr_wide >= WIN_W'(CHAR_BASE))
                   && (addr_wide < WIN_W'(CHAR_BASE) + WIN_W'(CHAR_SIZE));
   assign is_port   = (address[RAM_AW-1:1] == '0);
   assign ram_sel   = is_port ? SEL_PORT : SEL_RAM;

   assign basic_off  = address - RAM_AW'(BASIC_BASE);
   assign kernel_off = address - RAM_AW'(KERNEL_BASE);
   assign char_off   = address - RAM_AW'(CHAR_BASE);

   assign load = (func == FUNC_LOAD_BASIC) || (func == FUNC_LOAD_KERNEL)
              || (func == FUNC_LOAD_CHAR);

   assign basic_addr  = load ? address[BASIC_AW-1:0]  : basic_off[BASIC_AW-1:0];
   assign kernel_addr = load ? address[KERNEL_AW-1:0] : kernel_off[KERNEL_AW-1:0];
   assign char_addr   = load ? address[CHAR_AW-1:0]   : char_off[CHAR_AW-1:0];

   always_comb begin
      dec = '{sel: SEL_ZERO, source: SRC_RAM, default: 1'b0};
      unique case (func)
         FUNC_MAPPED_READ: begin
            priority if (in_basic) begin
               if (bank_bits[0]) begin
                  dec.sel    = SEL_BASIC;
                  dec.source = SRC_BASIC;
               end else begin
                  dec.sel = ram_sel;
               end
            end else if (in_kernel) begin
               if (bank_bits[1]) begin
                  dec.sel    = SEL_KERNEL;
                  dec.source = SRC_KERNEL;
               end else begin
                  dec.sel = ram_sel;
               end
            end else if (in_char) begin
               if (bank_bits[2]) begin
                  dec.sel = ram_sel;
               end else begin
                  dec.sel    = SEL_CHAR;
                  dec.source = SRC_CHAR;
               end
            end else begin
               dec.sel = ram_sel;
            end
         end
         FUNC_WRITE, FUNC_RAW_WRITE: begin
            dec.dir_we  = is_port && !address[0];
            dec.bank_we = is_port && address[0];
            dec.ram_we  = !is_port;
         end
         FUNC_RAW_READ: begin
            dec.sel = ram_sel;
         end
         FUNC_LOAD_BASIC: begin
            dec.source   = SRC_BASIC;
            dec.basic_we = (addr_wide < WIN_W'(BASIC_SIZE));
         end
         FUNC_LOAD_KERNEL: begin
            dec.source    = SRC_KERNEL;
            dec.kernel_we = (addr_wide < WIN_W'(KERNEL_SIZE));
         end
         FUNC_LOAD_CHAR: begin
            dec.source  = SRC_CHAR;
            dec.char_we = (addr_wide < WIN_W'(CHAR_SIZE));
         end
         default: begin
            dec.sel = SEL_ZERO;
         end
      endcase
   end

endmodule

// ===== design/banked_memory_map.sv =====
// ---------------------------------------------------------------------------
// Banked memory map
// 64 KiB bank-switched memory with port bytes, RAM and three loadable ROMs.
// ---------------------------------------------------------------------------
// After reset the block sweeps the whole RAM to zero, one byte per cycle,
// holding req_ready low until the sweep ends; port bytes reset at once. After
// that it takes one request beat per cycle while rsp_ready is held high.
// The single synchronous read or write of the RAM or a ROM happens at the
// edge that accepts the request, together with the read stage registers;
// the output register then loads from the read stage when it is empty or
// rsp_ready is high, so a stalled response holds the read stage.
// Writes and port updates take effect at the edge that accepts the request,
// so the next beat already sees them.
module banked_memory_map #(
   parameter int BASIC_BASE  = bmm_pkg::BASIC_BASE_DEF,
   parameter int BASIC_SIZE  = bmm_pkg::BASIC_SIZE_DEF,
   parameter int KERNEL_BASE = bmm_pkg::KERNEL_BASE_DEF,
   parameter int KERNEL_SIZE = bmm_pkg::KERNEL_SIZE_DEF,
   parameter int CHAR_BASE   = bmm_pkg::CHAR_BASE_DEF,
   parameter int CHAR_SIZE   = bmm_pkg::CHAR_SIZE_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [2:0]                  req_func,
   input  logic [bmm_pkg::RAM_AW-1:0]  req_address,
   input  logic [bmm_pkg::DATA_W-1:0]  req_write_data,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [bmm_pkg::DATA_W-1:0]  rsp_read_data,
   output logic [1:0]                  rsp_source
);
   import bmm_pkg::*;
   `include "banked_memory_map_macros.svh"

   localparam int BASIC_AW  = (BASIC_SIZE > 1)  ? $clog2(BASIC_SIZE)  : 1;
   localparam int KERNEL_AW = (KERNEL_SIZE > 1) ? $clog2(KERNEL_SIZE) : 1;
   localparam int CHAR_AW   = (CHAR_SIZE > 1)   ? $clog2(CHAR_SIZE)   : 1;
   localparam int RAM_DEPTH = 1 << RAM_AW;

   logic [DATA_W-1:0] ram_mem    [RAM_DEPTH];
   logic [DATA_W-1:0] basic_mem  [BASIC_SIZE];
   logic [DATA_W-1:0] kernel_mem [KERNEL_SIZE];
   logic [DATA_W-1:0] char_mem   [CHAR_SIZE];

   state_type         state_ff, state_in;
   logic [RAM_AW-1:0] clear_addr_ff, clear_addr_in;
   logic              clearing;

   logic [DATA_W-1:0] dir_ff, dir_in;
   logic [DATA_W-1:0] bank_ff, bank_in;

   dec_type              dec;
   logic [BASIC_AW-1:0]  basic_addr;
   logic [KERNEL_AW-1:0] kernel_addr;
   logic [CHAR_AW-1:0]   char_addr;

   logic              req_fire;
   logic              out_load;
   logic              ram_we;
   logic [RAM_AW-1:0] ram_waddr;
   logic [DATA_W-1:0] ram_wdata;

   logic [DATA_W-1:0] ram_rdata_ff;
   logic [DATA_W-1:0] basic_rdata_ff;
   logic [DATA_W-1:0] kernel_rdata_ff;
   logic [DATA_W-1:0] char_rdata_ff;

   logic              s1_valid_ff, s1_valid_in;
   sel_type           s1_sel_ff;
   logic [1:0]        s1_source_ff;
   logic [DATA_W-1:0] s1_port_ff;
   logic [DATA_W-1:0] s1_data;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_read_data_ff;
   logic [1:0]        rsp_source_ff;

   bmm_decode #(
      .BASIC_BASE  (BASIC_BASE),
      .BASIC_SIZE  (BASIC_SIZE),
      .KERNEL_BASE (KERNEL_BASE),
      .KERNEL_SIZE (KERNEL_SIZE),
      .CHAR_BASE   (CHAR_BASE),
      .CHAR_SIZE   (CHAR_SIZE),
      .BASIC_AW    (BASIC_AW),
      .KERNEL_AW   (KERNEL_AW),
      .CHAR_AW     (CHAR_AW)
   ) u_decode (
      .func        (req_func),
      .address     (req_address),
      .bank_bits   (bank_ff[2:0]),
      .dec         (dec),
      .basic_addr  (basic_addr),
      .kernel_addr (kernel_addr),
      .char_addr   (char_addr)
   );

   // RAM clearing sequencer
   always_comb begin
      state_in      = state_ff;
      clear_addr_in = clear_addr_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clear_addr_in = clear_addr_ff + 1'b1;
            if (clear_addr_ff == '1) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            clear_addr_in = clear_addr_ff;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      unique case (state_ff)
         ST_CLEAR: clearing = 1'b1;
         ST_RUN:   clearing = 1'b0;
         default:  clearing = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clear_addr_ff <= '0;
      end else begin
         state_ff      <= state_in;
         clear_addr_ff <= clear_addr_in;
      end
   end

   // Handshake
   assign out_load  = !rsp_valid_ff || rsp_ready;
   assign req_ready = !clearing && (!s1_valid_ff || out_load);
   assign req_fire  = req_valid && req_ready;

   // Port bytes
   assign dir_in  = (req_fire && dec.dir_we)  ? req_write_data : dir_ff;
   assign bank_in = (req_fire && dec.bank_we) ? req_write_data : bank_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_ff  <= DIR_RESET;
         bank_ff <= BANK_RESET;
      end else begin
         dir_ff  <= dir_in;
         bank_ff <= bank_in;
      end
   end

   // Memories
   assign ram_we    = clearing || (req_fire && dec.ram_we);
   assign ram_waddr = clearing ? clear_addr_ff : req_address;
   assign ram_wdata = clearing ? '0 : req_write_data;

   always_ff @(posedge clock) begin
      if (ram_we) begin
         ram_mem[ram_waddr] <= ram_wdata;
      end
      if (req_fire && (dec.sel == SEL_RAM)) begin
         ram_rdata_ff <= ram_mem[req_address];
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && dec.basic_we) begin
         basic_mem[basic_addr] <= req_write_data;
      end
      if (req_fire && (dec.sel == SEL_BASIC)) begin
         basic_rdata_ff <= basic_mem[basic_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && dec.kernel_we) begin
         kernel_mem[kernel_addr] <= req_write_data;
      end
      if (req_fire && (dec.sel == SEL_KERNEL)) begin
         kernel_rdata_ff <= kernel_mem[kernel_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && dec.char_we) begin
         char_mem[char_addr] <= req_write_data;
      end
      if (req_fire && (dec.sel == SEL_CHAR)) begin
         char_rdata_ff <= char_mem[char_addr];
      end
   end

   // Read stage
   always_comb begin
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (out_load) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_sel_ff    <= dec.sel;
         s1_source_ff <= dec.source;
         s1_port_ff   <= req_address[0] ? bank_ff : dir_ff;
      end
   end

   always_comb begin
      unique case (s1_sel_ff)
         SEL_ZERO:   s1_data = '0;
         SEL_PORT:   s1_data = s1_port_ff;
         SEL_RAM:    s1_data = ram_rdata_ff;
         SEL_BASIC:  s1_data = basic_rdata_ff;
         SEL_KERNEL: s1_data = kernel_rdata_ff;
         SEL_CHAR:   s1_data = char_rdata_ff;
         default:    s1_data = '0;
      endcase
   end

   // Output register
   assign rsp_valid_in = out_load ? s1_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load && s1_valid_ff) begin
         rsp_read_data_ff <= s1_data;
         rsp_source_ff    <= s1_source_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_read_data_ff;
   assign rsp_source    = rsp_source_ff;

   // Checks
   `BMM_ASSERT_NOW(a_no_beat_while_clearing, clock, reset, state_ff == ST_CLEAR, !req_ready)
   `BMM_ASSERT_NEXT(a_fire_fills_stage, clock, reset, req_fire, s1_valid_ff)
   `BMM_ASSERT_NEXT(a_stalled_stage_holds, clock, reset, s1_valid_ff && !out_load,
                    s1_valid_ff && $stable(s1_sel_ff) && $stable(s1_source_ff))
   `BMM_ASSERT_NEXT(a_stage_feeds_output, clock, reset, s1_valid_ff && out_load, rsp_valid_ff)

endmodule

// ===== tb/banked_memory_map_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Banked memory map checker
// Watches both channels of the banked memory map, keeps its own image of the
// RAM, port bytes and ROMs, works out the reply to every request beat taken
// and compares each response beat with the oldest reply still awaited.
// ---------------------------------------------------------------------------
module banked_memory_map_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [2:0]  req_func,
   input  logic [15:0] req_address,
   input  logic [7:0]  req_write_data,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [7:0]  rsp_read_data,
   input  logic [1:0]  rsp_source,
   output int          error_count,
   output int          pending_count
);
   import bmm_pkg::*;

   typedef struct packed {
      logic [7:0] read_data;
      logic [1:0] source;
   } reply_type;

   reply_type  awaited_replies[$];
   reply_type  oldest;
   logic [7:0] ram_image [65536];
   logic [7:0] basic_image [BASIC_SIZE_DEF];
   logic [7:0] kernel_image [KERNEL_SIZE_DEF];
   logic [7:0] char_image [CHAR_SIZE_DEF];
   logic [7:0] dir_reg;
   logic [7:0] bank_reg;

   function automatic bit in_window(input int a, input int base, input int size);
      return a >= base && a < base + size;
   endfunction

   function automatic logic [7:0] cpu_byte(input logic [15:0] a);
      if (a == 16'd0) return dir_reg;
      if (a == 16'd1) return bank_reg;
      return ram_image[a];
   endfunction

   function automatic reply_type resolve_access(input logic [2:0] f, input logic [15:0] a,
                                                input logic [7:0] d);
      reply_type r;
      int        ai;
      r  = '0;
      ai = int'(a);
      case (f)
         FUNC_MAPPED_READ: begin
            if (in_window(ai, BASIC_BASE_DEF, BASIC_SIZE_DEF)) begin
               if (bank_reg[0]) begin
                  r.read_data = basic_image[ai - BASIC_BASE_DEF];
                  r.source    = SRC_BASIC;
               end else begin
                  r.read_data = cpu_byte(a);
               end
            end else if (in_window(ai, KERNEL_BASE_DEF, KERNEL_SIZE_DEF)) begin
               if (bank_reg[1]) begin
                  r.read_data = kernel_image[ai - KERNEL_BASE_DEF];
                  r.source    = SRC_KERNEL;
               end else begin
                  r.read_data = cpu_byte(a);
               end
            end else if (in_window(ai, CHAR_BASE_DEF, CHAR_SIZE_DEF)) begin
               if (bank_reg[2]) begin
                  r.read_data = cpu_byte(a);
               end else begin
                  r.read_data = char_image[ai - CHAR_BASE_DEF];
                  r.source    = SRC_CHAR;
               end
            end else begin
               r.read_data = cpu_byte(a);
            end
         end
         FUNC_WRITE, FUNC_RAW_WRITE: begin
            if (a == 16'd0) dir_reg = d;
            else if (a == 16'd1) bank_reg = d;
            else ram_image[a] = d;
         end
         FUNC_RAW_READ: r.read_data = cpu_byte(a);
         FUNC_LOAD_BASIC: begin
            if (ai < BASIC_SIZE_DEF) basic_image[ai] = d;
            r.source = SRC_BASIC;
         end
         FUNC_LOAD_KERNEL: begin
            if (ai < KERNEL_SIZE_DEF) kernel_image[ai] = d;
            r.source = SRC_KERNEL;
         end
         FUNC_LOAD_CHAR: begin
            if (ai < CHAR_SIZE_DEF) char_image[ai] = d;
            r.source = SRC_CHAR;
         end
         default: ;
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         foreach (ram_image[i]) ram_image[i] = '0;
         dir_reg  = DIR_RESET;
         bank_reg = BANK_RESET;
         awaited_replies.delete();
         error_count   = 0;
         pending_count = 0;
      end else begin
         if (req_valid && req_ready)
            awaited_replies.push_back(resolve_access(req_func, req_address, req_write_data));
         if (rsp_valid && rsp_ready) begin
            if (awaited_replies.size() == 0) begin
               error_count++;
               $display("%0t: response beat with no reply awaited, actual data %02h source %0d",
                        $realtime, rsp_read_data, rsp_source);
            end else begin
               oldest = awaited_replies.pop_front();
               if (rsp_read_data !== oldest.read_data) begin
                  error_count++;
                  $display("%0t: read_data expected %02h actual %02h",
                           $realtime, oldest.read_data, rsp_read_data);
               end
               if (rsp_source !== oldest.source) begin
                  error_count++;
                  $display("%0t: source expected %0d actual %0d",
                           $realtime, oldest.source, rsp_source);
               end
            end
         end
         pending_count = awaited_replies.size();
      end
   end

endmodule

// ===== tb/tb_banked_memory_map.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Banked memory map testbench
// Drives request beats into the banked memory map: a directed pass over the
// ports, ROM loads and window edges, then random traffic under three idling
// patterns. A checker beside the block predicts and compares every reply.
// ---------------------------------------------------------------------------
module tb_banked_memory_map;
   import bmm_pkg::*;

   localparam logic [2:0] FUNC_UNUSED = 3'd7;
   localparam int RANDOM_BEATS = 1600;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_func = '0;
   logic [15:0] req_address = '0;
   logic [7:0]  req_write_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_read_data;
   logic [1:0]  rsp_source;

   int error_count;
   int pending_count;
   int send_idle = 25;
   int recv_idle = 56;

   logic [7:0] bank_shadow = BANK_RESET;
   bit         basic_seen [BASIC_SIZE_DEF];
   bit         kernel_seen [KERNEL_SIZE_DEF];
   bit         char_seen [CHAR_SIZE_DEF];

   banked_memory_map uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_func       (req_func),
      .req_address    (req_address),
      .req_write_data (req_write_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_read_data  (rsp_read_data),
      .rsp_source     (rsp_source)
   );

   banked_memory_map_checker checker_inst (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_func       (req_func),
      .req_address    (req_address),
      .req_write_data (req_write_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_read_data  (rsp_read_data),
      .rsp_source     (rsp_source),
      .error_count    (error_count),
      .pending_count  (pending_count)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle);
   end

   initial begin
      #2000000;
      $display("TB_ERROR");
      $finish;
   end

   function automatic logic [15:0] pick_address();
      int base_w;
      int size_w;
      case ($urandom_range(2))
         0: begin base_w = BASIC_BASE_DEF;  size_w = BASIC_SIZE_DEF;  end
         1: begin base_w = KERNEL_BASE_DEF; size_w = KERNEL_SIZE_DEF; end
         default: begin base_w = CHAR_BASE_DEF; size_w = CHAR_SIZE_DEF; end
      endcase
      case ($urandom_range(9))
         0: return 16'($urandom_range(1));
         1: return 16'($urandom_range(63, 2));
         2: return 16'(base_w + $urandom_range(15));
         3: return 16'(base_w + size_w - 1 - $urandom_range(15));
         4: return ($urandom_range(1) == 0) ? 16'(base_w - 1) : 16'(base_w + size_w);
         default: return 16'($urandom());
      endcase
   endfunction

   function automatic logic [15:0] pick_offset(input int size);
      case ($urandom_range(19)) inside
         [0:7]:   return 16'($urandom_range(15));
         [8:11]:  return 16'(size - 1 - $urandom_range(15));
         [12:16]: return 16'($urandom_range(size - 1));
         default: return 16'($urandom_range(65535, size));
      endcase
   endfunction

   task automatic send_beat(input logic [2:0] f, input logic [15:0] a, input logic [7:0] d);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_func       <= f;
      req_address    <= a;
      req_write_data <= d;
      do @(posedge clock); while (!req_ready);
   endtask

   // A mapped read that would land on a ROM entry never loaded becomes a load
   // of that entry instead.
   task automatic issue(input logic [2:0] f, input logic [15:0] a, input logic [7:0] d);
      logic [2:0] func_q;
      logic [15:0] addr_q;
      int ai;
      func_q = f;
      addr_q = a;
      ai     = int'(a);
      if (f == FUNC_MAPPED_READ) begin
         if (ai >= BASIC_BASE_DEF && ai < BASIC_BASE_DEF + BASIC_SIZE_DEF) begin
            if (bank_shadow[0] && !basic_seen[ai - BASIC_BASE_DEF]) begin
               func_q = FUNC_LOAD_BASIC;
               addr_q = 16'(ai - BASIC_BASE_DEF);
            end
         end else if (ai >= KERNEL_BASE_DEF && ai < KERNEL_BASE_DEF + KERNEL_SIZE_DEF) begin
            if (bank_shadow[1] && !kernel_seen[ai - KERNEL_BASE_DEF]) begin
               func_q = FUNC_LOAD_KERNEL;
               addr_q = 16'(ai - KERNEL_BASE_DEF);
            end
         end else if (ai >= CHAR_BASE_DEF && ai < CHAR_BASE_DEF + CHAR_SIZE_DEF) begin
            if (!bank_shadow[2] && !char_seen[ai - CHAR_BASE_DEF]) begin
               func_q = FUNC_LOAD_CHAR;
               addr_q = 16'(ai - CHAR_BASE_DEF);
            end
         end
      end
      case (func_q)
         FUNC_WRITE, FUNC_RAW_WRITE: if (addr_q == 16'd1) bank_shadow = d;
         FUNC_LOAD_BASIC:  if (int'(addr_q) < BASIC_SIZE_DEF)  basic_seen[addr_q] = 1'b1;
         FUNC_LOAD_KERNEL: if (int'(addr_q) < KERNEL_SIZE_DEF) kernel_seen[addr_q] = 1'b1;
         FUNC_LOAD_CHAR:   if (int'(addr_q) < CHAR_SIZE_DEF)   char_seen[addr_q] = 1'b1;
         default: ;
      endcase
      send_beat(func_q, addr_q, d);
   endtask

   initial begin
      logic [2:0]  f;
      logic [15:0] a;
      int          r;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      issue(FUNC_RAW_READ, 16'h0000, 8'h00);
      issue(FUNC_MAPPED_READ, 16'h0001, 8'hFF);
      issue(FUNC_MAPPED_READ, 16'h0002, 8'h00);
      issue(FUNC_LOAD_BASIC, 16'h0000, 8'hFF);
      issue(FUNC_LOAD_BASIC, 16'(BASIC_SIZE_DEF - 1), 8'h5A);
      issue(FUNC_LOAD_KERNEL, 16'h0000, 8'h81);
      issue(FUNC_LOAD_KERNEL, 16'(KERNEL_SIZE_DEF - 1), 8'h7E);
      issue(FUNC_LOAD_CHAR, 16'h0000, 8'hC3);
      issue(FUNC_LOAD_CHAR, 16'(CHAR_SIZE_DEF - 1), 8'h3C);
      issue(FUNC_LOAD_BASIC, 16'(BASIC_SIZE_DEF), 8'h11);
      issue(FUNC_LOAD_CHAR, 16'hFFFF, 8'h22);
      issue(FUNC_MAPPED_READ, 16'(BASIC_BASE_DEF), 8'h00);
      issue(FUNC_MAPPED_READ, 16'(BASIC_BASE_DEF + BASIC_SIZE_DEF - 1), 8'h00);
      issue(FUNC_MAPPED_READ, 16'(KERNEL_BASE_DEF), 8'h00);
      issue(FUNC_MAPPED_READ, 16'hFFFF, 8'h00);
      issue(FUNC_MAPPED_READ, 16'(CHAR_BASE_DEF), 8'h00);
      issue(FUNC_WRITE, 16'h0001, 8'h33);
      issue(FUNC_MAPPED_READ, 16'(CHAR_BASE_DEF), 8'h00);
      issue(FUNC_MAPPED_READ, 16'(CHAR_BASE_DEF + CHAR_SIZE_DEF - 1), 8'h00);
      issue(FUNC_RAW_WRITE, 16'h0001, 8'hF4);
      issue(FUNC_WRITE, 16'hFFFF, 8'hA5);
      issue(FUNC_MAPPED_READ, 16'hFFFF, 8'h00);
      issue(FUNC_WRITE, 16'h0000, 8'hFF);
      issue(FUNC_RAW_READ, 16'h0000, 8'h00);
      issue(FUNC_UNUSED, 16'hFFFF, 8'hFF);
      issue(FUNC_WRITE, 16'h0001, BANK_RESET);
      issue(FUNC_MAPPED_READ, 16'(BASIC_BASE_DEF - 1), 8'h00);

      for (int n = 0; n < RANDOM_BEATS; n++) begin
         if (n == RANDOM_BEATS / 3) begin
            send_idle = 56;
            recv_idle = 25;
         end
         if (n == 2 * RANDOM_BEATS / 3) begin
            send_idle = 0;
            recv_idle = 0;
         end
         r = $urandom_range(99);
         if (r < 30) f = FUNC_MAPPED_READ;
         else if (r < 45) f = FUNC_WRITE;
         else if (r < 60) f = FUNC_RAW_READ;
         else if (r < 70) f = FUNC_RAW_WRITE;
         else if (r < 78) f = FUNC_LOAD_BASIC;
         else if (r < 86) f = FUNC_LOAD_KERNEL;
         else if (r < 96) f = FUNC_LOAD_CHAR;
         else f = FUNC_UNUSED;
         case (f)
            FUNC_LOAD_BASIC:  a = pick_offset(BASIC_SIZE_DEF);
            FUNC_LOAD_KERNEL: a = pick_offset(KERNEL_SIZE_DEF);
            FUNC_LOAD_CHAR:   a = pick_offset(CHAR_SIZE_DEF);
            default:          a = pick_address();
         endcase
         issue(f, a, 8'($urandom_range(255)));
      end
      req_valid <= 1'b0;

      while (pending_count != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (error_count == 0 && pending_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+design
design/bmm_pkg.sv
design/bmm_decode.sv
design/banked_memory_map.sv
tb/banked_memory_map_checker.sv
tb/tb_banked_memory_map.sv
